@@ design/gcni_pkg.sv @@
// ----------------------------------------------------------------------------
// gcni_pkg
// Shared types and constants for the grid cell neighbor index block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcni_pkg;

    // Grid limits and field widths
    localparam int MAX_COLS        = 256;
    localparam int MAX_ROWS        = 256;
    localparam int IDX_W           = 17;
    localparam int DIR_W           = 3;
    localparam int SIZE_W          = 9;
    localparam int POS_W           = 8;
    localparam int CFG_IDX_W       = 2;

    // Divider split: one quotient bit per step, two steps per stage
    localparam int DIV_STEPS       = POS_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

    // Cycles from an accepted start to the result strobe
    localparam int LATENCY         = DIV_STAGES + 4;

    typedef enum logic [1:0] {
        MODE_SQUARE = 2'd0,
        MODE_HEX    = 2'd1,
        MODE_TRI    = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILING_MODE = 2'd0,
        REG_GRID_COLS   = 2'd1,
        REG_GRID_ROWS   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [IDX_W-1:0] cell_index;
        logic [DIR_W-1:0] direction;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] neighbor_cell;
        logic             found;
    } t_out_item;

    // One stage of the row/column divider
    typedef struct packed {
        logic             valid;
        logic             in_grid;
        logic             orient;
        logic [DIR_W-1:0] dir;
        logic [SIZE_W-1:0] rem;
        logic [POS_W-1:0] low;
        logic [POS_W-1:0] quo;
    } t_div_stage;

    // Saturate a size register into [1, maxv]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] res;
        begin
            if (v == '0) begin
                res = SIZE_W'(1);
            end else if (v > maxv) begin
                res = maxv;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

    // One restoring division step: shift in the next dividend bit
    function automatic t_div_stage div_step(input t_div_stage s,
                                            input logic [SIZE_W-1:0] divisor);
        t_div_stage        ns;
        logic [SIZE_W:0]   trial;
        logic              qbit;
        begin
            ns    = s;
            trial = {s.rem, s.low[POS_W-1]};
            qbit  = (trial >= {1'b0, divisor});
            if (qbit) begin
                ns.rem = SIZE_W'(trial - {1'b0, divisor});
            end else begin
                ns.rem = trial[SIZE_W-1:0];
            end
            ns.low = {s.low[POS_W-2:0], 1'b0};
            ns.quo = {s.quo[POS_W-2:0], qbit};
            return ns;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/grid_cell_neighbor_index.sv @@
// ----------------------------------------------------------------------------
// grid_cell_neighbor_index
// Neighbor lookup for square, hex offset-row and triangle tilings.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with an item (cell index, direction) on i_item; an item is
//   taken at every edge with start high and busy low. busy stays low, so a
//   new item may follow every cycle: one item per cycle sustained.
//   Each transfer returns exactly one result on o_result, marked by o_valid
//   for one cycle. Results leave in the order the items came in.
//   The row/column divider sits in the middle: the linear index is split
//   into row and column by a restoring divide of eight quotient bits, two bits
//   per stage over four stages. Around it sit an input register, a grid range
//   check, the neighbor offset stage and the multiply-add output stage.
//   Configuration: i_cfg_valid/o_cfg_ready with a register index and data.
//   o_cfg_ready is always high; write only while no item is in flight.
//   Reset (synchronous, active low) clears all stage valid bits and restores
//   square mode with a 1 x 1 grid. There is no receiver stall: results are
//   presented once and must be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_neighbor_index
    import gcni_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output      logic                 busy,
    input  wire t_in_item             i_item,
    output      logic                 o_valid,
    output      t_out_item            o_result,
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]    i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_mode             r_mode;
    logic [SIZE_W-1:0] r_cols_raw;
    logic [SIZE_W-1:0] r_rows_raw;
    logic [SIZE_W-1:0] cols_c;
    logic [SIZE_W-1:0] rows_c;
    logic [IDX_W-1:0]  r_cells;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SQUARE;
            r_cols_raw <= SIZE_W'(1);
            r_rows_raw <= SIZE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TILING_MODE: r_mode     <= t_mode'(i_cfg_data[1:0]);
                REG_GRID_COLS:   r_cols_raw <= i_cfg_data;
                REG_GRID_ROWS:   r_rows_raw <= i_cfg_data;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign cols_c = clamp_size(r_cols_raw, SIZE_W'(MAX_COLS));
    assign rows_c = clamp_size(r_rows_raw, SIZE_W'(MAX_ROWS));

    // Cell count of the grid, registered from the clamped size registers
    always_ff @(posedge i_clk) begin
        r_cells <= IDX_W'(rows_c * cols_c);
    end

    // ------------------------------------------------------------------
    // Input register: strip the triangle orientation bit
    // ------------------------------------------------------------------
    logic              r_in_valid;
    logic [IDX_W-1:0]  r_in_cell;
    logic              r_in_orient;
    logic [DIR_W-1:0]  r_in_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_cell   <= (r_mode == MODE_TRI) ? {1'b0, i_item.cell_index[IDX_W-1:1]}
                                            : i_item.cell_index;
        r_in_orient <= i_item.cell_index[0];
        r_in_dir    <= i_item.direction;
    end

    // ------------------------------------------------------------------
    // Range check and divider setup. Inside the grid the row is below
    // MAX_ROWS, so the top byte of the index is already below cols.
    // ------------------------------------------------------------------
    t_div_stage r_div [DIV_STAGES+1];
    t_div_stage n_div [DIV_STAGES+1];

    always_comb begin
        n_div[0].valid   = r_in_valid;
        n_div[0].in_grid = (r_in_cell < r_cells);
        n_div[0].orient  = r_in_orient;
        n_div[0].dir     = r_in_dir;
        n_div[0].rem     = {1'b0, r_in_cell[2*POS_W-1:POS_W]};
        n_div[0].low     = r_in_cell[POS_W-1:0];
        n_div[0].quo     = '0;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            n_div[s] = r_div[s-1];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                n_div[s] = div_step(n_div[s], cols_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s <= DIV_STAGES; s++) begin
            if (!i_rst_n) begin
                r_div[s].valid <= 1'b0;
            end else begin
                r_div[s].valid <= n_div[s].valid;
            end
            r_div[s].in_grid <= n_div[s].in_grid;
            r_div[s].orient  <= n_div[s].orient;
            r_div[s].dir     <= n_div[s].dir;
            r_div[s].rem     <= n_div[s].rem;
            r_div[s].low     <= n_div[s].low;
            r_div[s].quo     <= n_div[s].quo;
        end
    end

    // ------------------------------------------------------------------
    // Neighbor offset: row/column step by mode, parity and orientation
    // ------------------------------------------------------------------
    t_div_stage        d_last;
    logic [POS_W-1:0]  row0;
    logic [POS_W-1:0]  col0;
    logic              par;
    logic              dir_ok;
    logic [1:0]        dr;
    logic [1:0]        dc;
    logic [SIZE_W:0]   tr;
    logic [SIZE_W:0]   tc;
    logic              n_ok;

    assign d_last = r_div[DIV_STAGES];
    assign row0   = d_last.quo;
    assign col0   = d_last.rem[POS_W-1:0];
    assign par    = row0[0];

    // dr/dc are two's complement steps of -1, 0 or +1
    always_comb begin
        dir_ok = 1'b0;
        dr     = 2'b00;
        dc     = 2'b00;
        case (r_mode)
            MODE_SQUARE: begin
                dir_ok = (d_last.dir < DIR_W'(4));
                case (d_last.dir[1:0])
                    2'd0:    dr = 2'b01;
                    2'd1:    dr = 2'b11;
                    2'd2:    dc = 2'b11;
                    default: dc = 2'b01;
                endcase
            end
            MODE_HEX: begin
                dir_ok = (d_last.dir < DIR_W'(6));
                case (d_last.dir)
                    3'd0: begin dc = 2'b01; end
                    3'd1: begin dr = 2'b01; dc = {1'b0, par}; end
                    3'd2: begin dr = 2'b01; dc = par ? 2'b00 : 2'b11; end
                    3'd3: begin dc = 2'b11; end
                    3'd4: begin dr = 2'b11; dc = par ? 2'b00 : 2'b11; end
                    default: begin dr = 2'b11; dc = {1'b0, par}; end
                endcase
            end
            MODE_TRI: begin
                dir_ok = (d_last.dir < DIR_W'(3));
                if (!d_last.orient) begin
                    // pointing up
                    case (d_last.dir[1:0])
                        2'd0:    dr = 2'b11;
                        2'd1:    dc = par ? 2'b00 : 2'b11;
                        default: dc = {1'b0, par};
                    endcase
                end else begin
                    // pointing down
                    case (d_last.dir[1:0])
                        2'd0:    dr = 2'b01;
                        2'd1:    dc = {1'b0, !par};
                        default: dc = par ? 2'b11 : 2'b00;
                    endcase
                end
            end
            default: begin
                dir_ok = 1'b0;
            end
        endcase
    end

    assign tr   = {2'b00, row0} + {{(SIZE_W-1){dr[1]}}, dr};
    assign tc   = {2'b00, col0} + {{(SIZE_W-1){dc[1]}}, dc};
    assign n_ok = d_last.in_grid && dir_ok
               && !tr[SIZE_W] && (tr[SIZE_W-1:0] < rows_c)
               && !tc[SIZE_W] && (tc[SIZE_W-1:0] < cols_c);

    logic             r_nb_valid;
    logic             r_nb_ok;
    logic [POS_W-1:0] r_nb_row;
    logic [POS_W-1:0] r_nb_col;
    logic             r_nb_orient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb_valid <= 1'b0;
        end else begin
            r_nb_valid <= d_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb_ok     <= n_ok;
        r_nb_row    <= tr[POS_W-1:0];
        r_nb_col    <= tc[POS_W-1:0];
        r_nb_orient <= d_last.orient;
    end

    // ------------------------------------------------------------------
    // Output: linear index = row * cols + col, triangles append the
    // opposite orientation bit
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] lin;
    logic [IDX_W-1:0] n_index;

    assign lin     = IDX_W'(r_nb_row * cols_c) + IDX_W'(r_nb_col);
    assign n_index = (r_mode == MODE_TRI) ? {lin[IDX_W-2:0], !r_nb_orient} : lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_nb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.neighbor_cell <= r_nb_ok ? n_index : '0;
        o_result.found         <= r_nb_ok;
    end

endmodule

`default_nettype wire

@@ design/gcni_checker.sv @@
// ----------------------------------------------------------------------------
// gcni_checker
// Port-level checks for the grid cell neighbor index block.
// ----------------------------------------------------------------------------
`default_nettype none

module gcni_checker
    import gcni_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire t_in_item             i_item,
    input wire logic                 o_valid,
    input wire t_out_item            o_result,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [SIZE_W-1:0]    i_cfg_data
);

    // every transfer yields its result after a fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("result missing after accepted start");

    // no result without a matching accepted transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching start");

    // a missing neighbor reads as index zero
    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.found |-> o_result.neighbor_cell == '0)
        else $error("nonzero index with found low");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind grid_cell_neighbor_index gcni_checker u_gcni_checker (.*);

`default_nettype wire
